### hdl/lpad_pkg.sv
// Package: shared types and codes for the length-prefixed argument decoder.
`timescale 1ns / 1ps
`default_nettype none

package lpad_pkg;

	// Most arguments one message may carry
	localparam int unsigned MaxFields = 4;
	// Results buffered toward the output
	localparam int unsigned ResDepth = 4;

	// Header byte layout
	localparam logic [7:0] HdrFlagMask = 8'h80;
	localparam logic [7:0] HdrLenMask  = 8'h3f;

	// Input item codes
	localparam logic FuncStart = 1'b0;
	localparam logic FuncByte  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_END    = 2'd1,
		KIND_STATUS = 2'd2,
		KIND_RSVD   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FLAG = 2'd1,
		ST_OVERRUN = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  field_index;
		logic [7:0]  out_byte;
		status_t     status;
		logic [2:0]  fields_decoded;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

### hdl/length_prefixed_arg_decoder_top.sv
// Top level: length-prefixed argument decoder with input register and result queue.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | sink      | in_valid / in_stall  | func, message_length, field_limit, data_byte
//  out     | source    | out_valid / out_stall| kind, field_index, out_byte, status,
//          |           |                    | fields_decoded, last
//
// An accepted request lands in the input register; from there a single pass of counter
// updates and compares decodes it and writes its results, none up to three, into a
// four-entry result queue. One request per cycle is taken while the queue has room
// for the results it makes; results leave one per cycle while out_stall is low.
// Reset clears the decoder state and empties the queue. Stalling the output only
// fills the queue, then stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_arg_decoder_top
	import lpad_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [15:0] message_length,
	input  wire logic [3:0]  field_limit,
	input  wire logic [7:0]  data_byte,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [1:0]       field_index,
	output logic [7:0]       out_byte,
	output logic [1:0]       status,
	output logic [2:0]       fields_decoded,
	output logic             last
);

	localparam int unsigned PtrW = $clog2(ResDepth);
	localparam int unsigned CntW = $clog2(ResDepth + 1);

	// Input register
	logic        valid_s1;
	logic        func_s1;
	logic [15:0] mlen_s1;
	logic [3:0]  flim_s1;
	logic [7:0]  byte_s1;

	// Decoder state
	phase_t      phase_q;
	logic [2:0]  fields_done_q;
	logic [5:0]  field_left_q;
	logic [15:0] msg_left_q;
	logic [2:0]  fields_wanted_q;

	// Next state and results of the decode pass
	phase_t      phase_d;
	logic [2:0]  fields_done_d;
	logic [5:0]  field_left_d;
	logic [15:0] msg_left_d;
	logic [2:0]  fields_wanted_d;
	res_t        res [3];
	logic [1:0]  res_cnt;
	logic        do_end;
	logic [5:0]  flen;
	logic        go;

	// Result queue
	res_t            queue_q [ResDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            pop;
	res_t            head;

	// Advance the input register when it is empty or its request is decoded
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			mlen_s1 <= message_length;
			flim_s1 <= field_limit;
			byte_s1 <= data_byte;
		end
	end

	// Decode one request against the current state
	always_comb begin
		phase_d         = phase_q;
		fields_done_d   = fields_done_q;
		field_left_d    = field_left_q;
		msg_left_d      = msg_left_q;
		fields_wanted_d = fields_wanted_q;
		res[0]          = '0;
		res[1]          = '0;
		res[2]          = '0;
		res_cnt         = 2'd0;
		do_end          = 1'b0;
		flen            = byte_s1[5:0] & HdrLenMask[5:0];

		if (func_s1 == FuncStart) begin
			// Clamp the wanted count and restart
			fields_wanted_d = (flim_s1 > 4'(MaxFields)) ? 3'(MaxFields) : flim_s1[2:0];
			msg_left_d      = mlen_s1;
			fields_done_d   = 3'd0;
			field_left_d    = 6'd0;
			if (fields_wanted_d == 3'd0 || msg_left_d == 16'd0) begin
				phase_d              = PH_DONE;
				res[0].kind          = KIND_STATUS;
				res[0].status        = ST_OK;
				res[0].fields_decoded = 3'd0;
				res_cnt              = 2'd1;
			end else begin
				phase_d = PH_HEADER;
			end
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					msg_left_d = msg_left_q - 16'd1;
					if ((byte_s1 & HdrFlagMask) == 8'h00) begin
						// Header flag missing
						phase_d               = PH_DONE;
						res[0].kind           = KIND_STATUS;
						res[0].field_index    = fields_done_q[1:0];
						res[0].status         = ST_NO_FLAG;
						res[0].fields_decoded = fields_done_q;
						res_cnt               = 2'd1;
					end else if ({10'd0, flen} > msg_left_d) begin
						// Field runs past the message
						phase_d               = PH_DONE;
						res[0].kind           = KIND_STATUS;
						res[0].field_index    = fields_done_q[1:0];
						res[0].status         = ST_OVERRUN;
						res[0].fields_decoded = fields_done_q;
						res_cnt               = 2'd1;
					end else if (flen == 6'd0) begin
						field_left_d = 6'd0;
						do_end       = 1'b1;
					end else begin
						field_left_d = flen;
						phase_d      = PH_DATA;
					end
				end
				PH_DATA: begin
					// Copy one data byte
					res[0].kind        = KIND_DATA;
					res[0].field_index = fields_done_q[1:0];
					res[0].out_byte    = byte_s1;
					res_cnt            = 2'd1;
					msg_left_d         = msg_left_q - 16'd1;
					field_left_d       = field_left_q - 6'd1;
					do_end             = (field_left_d == 6'd0);
				end
				default: begin
					// Drop bytes while idle or done
				end
			endcase
		end

		// Close the field; finish the message when the wanted count is met or its bytes run out
		if (do_end) begin
			res[res_cnt].kind        = KIND_END;
			res[res_cnt].field_index = fields_done_d[1:0];
			res_cnt                  = res_cnt + 2'd1;
			fields_done_d            = fields_done_d + 3'd1;
			if (fields_done_d >= fields_wanted_d || msg_left_d == 16'd0) begin
				phase_d                       = PH_DONE;
				res[res_cnt].kind             = KIND_STATUS;
				res[res_cnt].status           = ST_OK;
				res[res_cnt].fields_decoded   = fields_done_d;
				res_cnt                       = res_cnt + 2'd1;
			end else begin
				phase_d = PH_HEADER;
			end
		end

		// Mark the last result of this request
		if (res_cnt != 2'd0) begin
			res[res_cnt - 2'd1].last = 1'b1;
		end
	end

	// Take the request when the queue has room for all of its results
	assign go = valid_s1 && ({{(CntW-2){1'b0}}, res_cnt} <= (CntW'(ResDepth) - count_q));

	// Hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			fields_done_q   <= 3'd0;
			field_left_q    <= 6'd0;
			msg_left_q      <= 16'd0;
			fields_wanted_q <= 3'd0;
		end else if (go) begin
			phase_q         <= phase_d;
			fields_done_q   <= fields_done_d;
			field_left_q    <= field_left_d;
			msg_left_q      <= msg_left_d;
			fields_wanted_q <= fields_wanted_d;
		end
	end

	// Write results into the queue
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (go && (2'(k) < res_cnt)) begin
				queue_q[wr_ptr_q + PtrW'(k)] <= res[k];
			end
		end
	end

	assign pop  = out_valid && !out_stall;
	assign head = queue_q[rd_ptr_q];

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (go) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(res_cnt);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			count_q <= count_q + (go ? CntW'(res_cnt) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
		end
	end

	// Drive the output channel from the queue head
	assign out_valid      = (count_q != '0);
	assign kind           = head.kind;
	assign field_index    = head.field_index;
	assign out_byte       = head.out_byte;
	assign status         = head.status;
	assign fields_decoded = head.fields_decoded;
	assign last           = head.last;

	// Queue never holds more results than it has entries
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(ResDepth))
		else $error("result queue overfilled");

	// A data phase always has bytes of the field to go
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> field_left_q != 6'd0)
		else $error("data phase with empty field");

	// Awaiting a header means more fields are still wanted
	a_header_wanted: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> fields_done_q < fields_wanted_q)
		else $error("header phase with no fields wanted");

	// A final status always closes its request
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> last)
		else $error("final status without last");

endmodule

`default_nettype wire

### tb/sv/length_prefixed_arg_decoder_top_tb.sv
// Testbench: directed table and random messages for the length-prefixed argument decoder.
`timescale 1ns / 1ps

module length_prefixed_arg_decoder_top_tb;
	import lpad_pkg::*;

	localparam int unsigned RandomItems = 254;
	localparam int unsigned NumDirected = 26;
	localparam int unsigned DrainCycles = 20;
	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned MaxReports  = 10;

	// How a request's results are checked
	typedef enum logic [1:0] {
		CHK_MODEL = 2'd0,	// predicted
		CHK_TYPED = 2'd1,	// one result, typed in the table
		CHK_QUIET = 2'd2	// no result at all
	} chk_t;

	typedef struct packed {
		logic        func;
		logic [15:0] mlen;
		logic [3:0]  flim;
		logic [7:0]  dbyte;
		chk_t        check;
		res_t        want;
	} request_t;

	localparam res_t NoRes = '0;

	// Directed requests: extremes, every error, empty and abandoned messages
	localparam request_t DirectedTbl [NumDirected] = '{
		// byte while idle is dropped
		'{FuncByte,  16'd0,     4'd0,  8'hff, CHK_QUIET, NoRes},
		// zero message length ends at once
		'{FuncStart, 16'd0,     4'd4,  8'h00, CHK_TYPED,
			'{KIND_STATUS, 2'd0, 8'd0, ST_OK, 3'd0, 1'b1}},
		// byte after final status is dropped
		'{FuncByte,  16'd0,     4'd0,  8'hff, CHK_QUIET, NoRes},
		// zero wanted count ends at once
		'{FuncStart, 16'd5,     4'd0,  8'h00, CHK_TYPED,
			'{KIND_STATUS, 2'd0, 8'd0, ST_OK, 3'd0, 1'b1}},
		// widest length, count clamped
		'{FuncStart, 16'hffff,  4'd15, 8'h00, CHK_QUIET, NoRes},
		// header without flag bit
		'{FuncByte,  16'd0,     4'd0,  8'h7f, CHK_TYPED,
			'{KIND_STATUS, 2'd0, 8'd0, ST_NO_FLAG, 3'd0, 1'b1}},
		'{FuncStart, 16'd3,     4'd1,  8'h00, CHK_QUIET, NoRes},
		// longest field overruns a short message
		'{FuncByte,  16'd0,     4'd0,  8'hbf, CHK_TYPED,
			'{KIND_STATUS, 2'd0, 8'd0, ST_OVERRUN, 3'd0, 1'b1}},
		// empty field, then a field that ends exactly at message end
		'{FuncStart, 16'd4,     4'd15, 8'h00, CHK_QUIET, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h80, CHK_MODEL, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'hc2, CHK_MODEL, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h00, CHK_MODEL, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'hff, CHK_MODEL, NoRes},
		// two fields, ended by the wanted count
		'{FuncStart, 16'd10,    4'd2,  8'h00, CHK_QUIET, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h81, CHK_MODEL, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h55, CHK_MODEL, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h81, CHK_MODEL, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'haa, CHK_MODEL, NoRes},
		// start in the middle of a field abandons it
		'{FuncStart, 16'd8,     4'd3,  8'h00, CHK_QUIET, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h83, CHK_MODEL, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h01, CHK_MODEL, NoRes},
		'{FuncStart, 16'd2,     4'd1,  8'h00, CHK_QUIET, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h80, CHK_MODEL, NoRes},
		// overrun on the second field
		'{FuncStart, 16'd3,     4'd4,  8'h00, CHK_QUIET, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h80, CHK_MODEL, NoRes},
		'{FuncByte,  16'd0,     4'd0,  8'h82, CHK_TYPED,
			'{KIND_STATUS, 2'd1, 8'd0, ST_OVERRUN, 3'd1, 1'b1}}
	};

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic        func           = 1'b0;
	logic [15:0] message_length = 16'd0;
	logic [3:0]  field_limit    = 4'd0;
	logic [7:0]  data_byte      = 8'd0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [1:0]  kind;
	logic [1:0]  field_index;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic [2:0]  fields_decoded;
	logic        last;

	length_prefixed_arg_decoder_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.message_length (message_length),
		.field_limit    (field_limit),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.field_index    (field_index),
		.out_byte       (out_byte),
		.status         (status),
		.fields_decoded (fields_decoded),
		.last           (last)
	);

	always #5 clk = ~clk;

	request_t requests[$];
	res_t     pending_results[$];
	res_t     step_results[$];
	int       total_items  = 0;
	int       sent_count   = 0;
	int       drive_idx    = -1;
	int       cycle_count  = 0;
	int       mismatches   = 0;
	int       results_seen = 0;
	int       data_seen    = 0;
	int       ends_seen    = 0;
	int       finals_seen  = 0;
	int       errors_seen  = 0;
	int       starts_taken = 0;

	// Decoder state as predicted
	phase_t      dec_phase      = PH_IDLE;
	logic [2:0]  dec_done       = 3'd0;
	logic [5:0]  dec_field_left = 6'd0;
	logic [15:0] dec_msg_left   = 16'd0;
	logic [2:0]  dec_wanted     = 3'd0;

	task automatic add_start(input logic [15:0] mlen, input logic [3:0] flim);
		request_t r;
		r = '{FuncStart, mlen, flim, 8'($urandom), CHK_MODEL, NoRes};
		requests.push_back(r);
	endtask

	task automatic add_byte(input logic [7:0] b);
		request_t r;
		r = '{FuncByte, 16'($urandom), 4'($urandom), b, CHK_MODEL, NoRes};
		requests.push_back(r);
	endtask

	task automatic emit(input kind_t k, input logic [1:0] idx, input logic [7:0] b,
			input status_t st, input logic [2:0] cnt);
		res_t r;
		r = '{k, idx, b, st, cnt, 1'b0};
		step_results.push_back(r);
	endtask

	task automatic finish_ok();
		dec_phase = PH_DONE;
		emit(KIND_STATUS, 2'd0, 8'd0, ST_OK, dec_done);
	endtask

	// Close a field; end the message when the count is met or bytes run out
	task automatic close_field();
		emit(KIND_END, dec_done[1:0], 8'd0, ST_OK, 3'd0);
		dec_done = dec_done + 3'd1;
		if (dec_done >= dec_wanted || dec_msg_left == 16'd0) begin
			finish_ok();
		end else begin
			dec_phase = PH_HEADER;
		end
	endtask

	// Advance the predicted decoder by one request
	task automatic decode_request(input request_t req);
		logic [7:0] hdr_len;
		step_results.delete();
		hdr_len = req.dbyte & HdrLenMask;
		if (req.func == FuncStart) begin
			dec_wanted = (req.flim > MaxFields) ? 3'(MaxFields) : req.flim[2:0];
			dec_msg_left = req.mlen;
			dec_done = 3'd0;
			dec_field_left = 6'd0;
			if (dec_wanted == 3'd0 || dec_msg_left == 16'd0) begin
				finish_ok();
			end else begin
				dec_phase = PH_HEADER;
			end
		end else if (dec_phase == PH_HEADER) begin
			dec_msg_left = dec_msg_left - 16'd1;
			if ((req.dbyte & HdrFlagMask) == 8'd0) begin
				dec_phase = PH_DONE;
				emit(KIND_STATUS, dec_done[1:0], 8'd0, ST_NO_FLAG, dec_done);
			end else if ({8'd0, hdr_len} > dec_msg_left) begin
				dec_phase = PH_DONE;
				emit(KIND_STATUS, dec_done[1:0], 8'd0, ST_OVERRUN, dec_done);
			end else if (hdr_len == 8'd0) begin
				dec_field_left = 6'd0;
				close_field();
			end else begin
				dec_field_left = hdr_len[5:0];
				dec_phase = PH_DATA;
			end
		end else if (dec_phase == PH_DATA) begin
			emit(KIND_DATA, dec_done[1:0], req.dbyte, ST_OK, 3'd0);
			dec_msg_left = dec_msg_left - 16'd1;
			dec_field_left = dec_field_left - 6'd1;
			if (dec_field_left == 6'd0) begin
				close_field();
			end
		end
		if (step_results.size() > 0) begin
			step_results[step_results.size() - 1].last = 1'b1;
		end
	endtask

	// Sender: bursts of requests with random gaps between them
	int       burst_left = 1;
	int       gap_left   = 0;
	request_t cur;
	always @(negedge clk) begin
		if (arst_n) begin
			// hold a request that has not been taken yet
			if (!(in_valid && drive_idx == sent_count)) begin
				if (in_valid) begin
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (sent_count < total_items) begin
					cur = requests[sent_count];
					drive_idx = sent_count;
					func <= cur.func;
					message_length <= cur.mlen;
					field_limit <= cur.flim;
					data_byte <= cur.dbyte;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switch among free, random, periodic and heavy stall patterns
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 80);
		end else begin
			stall_left--;
		end
		stall_tick++;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= (stall_tick % 4) != 0;
			default: out_stall <= $urandom_range(0, 9) < 8;
		endcase
	end

	// Predict on each taken request, check each taken result
	request_t req_taken;
	res_t     got;
	res_t     exp_r;
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count++;
			if (in_valid && !in_stall) begin
				req_taken = requests[sent_count];
				decode_request(req_taken);
				if (req_taken.func == FuncStart) begin
					starts_taken++;
				end
				case (req_taken.check)
					CHK_MODEL: begin
						foreach (step_results[k]) begin
							pending_results.push_back(step_results[k]);
						end
					end
					CHK_TYPED: pending_results.push_back(req_taken.want);
					default: ;
				endcase
				sent_count++;
			end
			if (out_valid && !out_stall) begin
				got = '{kind_t'(kind), field_index, out_byte, status_t'(status),
					fields_decoded, last};
				results_seen++;
				case (got.kind)
					KIND_DATA: data_seen++;
					KIND_END: ends_seen++;
					default: begin
						finals_seen++;
						if (got.status != ST_OK) begin
							errors_seen++;
						end
					end
				endcase
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MaxReports) begin
						$display("result %0d unexpected: kind=%0d idx=%0d byte=%02h st=%0d cnt=%0d last=%0d",
							results_seen, kind, field_index, out_byte, status,
							fields_decoded, last);
					end
				end else begin
					exp_r = pending_results.pop_front();
					if (got.kind !== exp_r.kind || got.field_index !== exp_r.field_index ||
							got.out_byte !== exp_r.out_byte || got.status !== exp_r.status ||
							got.fields_decoded !== exp_r.fields_decoded ||
							got.last !== exp_r.last) begin
						mismatches++;
						if (mismatches <= MaxReports) begin
							$display("result %0d: exp kind=%0d idx=%0d byte=%02h st=%0d cnt=%0d last=%0d",
								results_seen, exp_r.kind, exp_r.field_index, exp_r.out_byte,
								exp_r.status, exp_r.fields_decoded, exp_r.last);
							$display("           got kind=%0d idx=%0d byte=%02h st=%0d cnt=%0d last=%0d",
								kind, field_index, out_byte, status, fields_decoded, last);
						end
					end
				end
			end
		end
	end

	// Guard against a hung run
	initial begin
		wait (cycle_count >= CycleLimit);
		$display("timeout after %0d cycles, %0d requests taken", cycle_count, sent_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [7:0]  body[$];
		logic [7:0]  hdr;
		logic [15:0] mlen;
		logic [3:0]  lim;
		int          counted;
		int          want_n;
		int          nfields;
		int          flen;
		int          cut;

		counted = 0;
		// walk the directed table
		for (int i = 0; i < NumDirected; i++) begin
			requests.push_back(DirectedTbl[i]);
		end

		// random messages, mostly well formed
		while (counted < RandomItems) begin
			if ($urandom_range(0, 19) == 0) begin
				// noise: stray start and loose bytes
				add_start(16'($urandom), 4'($urandom));
				cut = $urandom_range(0, 4);
				for (int k = 0; k < cut; k++) begin
					add_byte(8'($urandom));
				end
				counted += 1 + cut;
			end else begin
				lim = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
				want_n = (lim > MaxFields) ? MaxFields : lim;
				nfields = want_n;
				if (want_n > 0 && $urandom_range(0, 3) == 0) begin
					nfields = $urandom_range(1, want_n);
				end
				body.delete();
				for (int f = 0; f < nfields; f++) begin
					flen = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 63)
						: $urandom_range(0, 4);
					hdr = {1'b1, 1'($urandom), 6'(flen)};
					// drop the flag bit now and then
					if ($urandom_range(0, 14) == 0) begin
						hdr[7] = 1'b0;
					end
					body.push_back(hdr);
					for (int k = 0; k < flen; k++) begin
						body.push_back(8'($urandom));
					end
				end
				mlen = 16'(body.size());
				case ($urandom_range(0, 9))
					0: mlen = 16'($urandom);
					1: begin
						if (body.size() > 0) begin
							mlen = 16'($urandom_range(0, body.size() - 1));
						end
					end
					2: mlen = 16'(body.size() + $urandom_range(1, 8));
					default: ;
				endcase
				cut = body.size();
				// abandon some messages part way with the next start
				if ($urandom_range(0, 9) == 0) begin
					cut = $urandom_range(0, body.size());
				end
				add_start(mlen, lim);
				for (int k = 0; k < cut; k++) begin
					add_byte(body[k]);
				end
				counted += 1 + cut;
				// trailing bytes, mostly after the final status
				if ($urandom_range(0, 7) == 0) begin
					flen = $urandom_range(1, 3);
					for (int k = 0; k < flen; k++) begin
						add_byte(8'($urandom));
					end
					counted += flen;
				end
			end
		end
		total_items = requests.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (sent_count == total_items);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		$display("run: %0d requests in %0d messages over %0d cycles", sent_count,
			starts_taken, cycle_count);
		$display("     %0d results: %0d data, %0d field ends, %0d finals (%0d errors), %0d bad",
			results_seen, data_seen, ends_seen, finals_seen, errors_seen, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### length_prefixed_arg_decoder_top.f
hdl/lpad_pkg.sv
hdl/length_prefixed_arg_decoder_top.sv
tb/sv/length_prefixed_arg_decoder_top_tb.sv
